// ===== rtl/cti_pkg.sv =====
package cti_pkg;

  localparam int VOLT_W   = 16;
  localparam int CODE_W   = 16;
  localparam int COUNT_W  = 5;
  localparam int INDEX_W  = 4;
  localparam int DIFF_W   = VOLT_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int QUO_W    = 16;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  localparam logic [CODE_W-1:0] CODE_MAX = 16'hFFFF;

  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_CONVERT = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_EVAL = 7'b0000100,
    ST_MUL  = 7'b0001000,
    ST_PREP = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

endpackage

// ===== rtl/calibration_table_interpolator_core.sv =====
// Calibration point table with piecewise-linear voltage to DAC code conversion. A write
// transaction (mode 0) stores one point and never raises busy. A convert
// transaction (mode 1) holds busy while the points in use (n, from entry_count) are read
// one per cycle from the single-port table. done pulses once the scan and evaluation end
// for an exact match or a clamped result; when interpolation is needed, one multiply and
// a 16-step restoring divider come between evaluation and done. dac_code is valid only in
// the cycle done is high; the receiver cannot stall, so it must take the result then.
module calibration_table_interpolator_core
  import cti_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     mode,
  input  logic [INDEX_W-1:0]       entry_index,
  input  logic signed [VOLT_W-1:0] entry_voltage,
  input  logic [CODE_W-1:0]        entry_code,
  input  logic signed [VOLT_W-1:0] voltage_in,
  output logic [CODE_W-1:0]        dac_code,
  output logic                     done,
  input  logic                     cfg_wr_en,
  input  logic [COUNT_W-1:0]       cfg_wr_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t state;

  logic [COUNT_W-1:0]       entry_count;
  logic [CNT_W-1:0]         n_used;
  logic [CNT_W-1:0]         iss_cnt;
  logic                     issue;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;

  logic [VOLT_W+CODE_W-1:0] table_mem [TABLE_DEPTH];
  logic [VOLT_W+CODE_W-1:0] rd_data;
  logic                     rd_vld;
  logic [IDX_W-1:0]         rd_idx;
  logic signed [VOLT_W-1:0] pv;
  logic [CODE_W-1:0]        pc;

  logic signed [VOLT_W-1:0] vin;
  logic                     match;
  logic [CODE_W-1:0]        match_c;
  logic                     found_hi;
  logic [IDX_W-1:0]         lo_idx;
  logic [IDX_W-1:0]         hi_idx;
  logic signed [VOLT_W-1:0] lo_v;
  logic signed [VOLT_W-1:0] hi_v;
  logic [CODE_W-1:0]        lo_c;
  logic [CODE_W-1:0]        hi_c;

  logic signed [DIFF_W-1:0] den_w;
  logic signed [DIFF_W-1:0] dc_w;
  logic signed [DIFF_W-1:0] dv_w;
  logic signed [DIFF_W-1:0] dc;
  logic signed [DIFF_W-1:0] dv;
  logic [DIFF_W-1:0]        den;
  logic signed [PROD_W-1:0] prod;
  logic [PROD_W-1:0]        mag_w;
  logic                     neg;
  logic [DIFF_W-1:0]        rem;
  logic [QUO_W-1:0]         quo;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [DIFF_W:0]          trial_w;
  logic                     ge_w;
  logic [DIFF_W:0]          q_mag_w;
  logic signed [DIFF_W:0]   q_s_w;
  logic signed [DIFF_W:0]   sum_s_w;
  logic [CODE_W-1:0]        result_w;

  assign busy = (state != ST_IDLE);

  // Points in use: a count of zero acts as one, and the count saturates at the depth.
  always_comb begin
    if (entry_count == '0) begin
      n_used = CNT_W'(1);
    end else if (32'(entry_count) > TABLE_DEPTH) begin
      n_used = CNT_W'(TABLE_DEPTH);
    end else begin
      n_used = CNT_W'(entry_count);
    end
  end

  assign wr_en   = start && !busy && (mode == MODE_WRITE) && (32'(entry_index) < TABLE_DEPTH);
  assign wr_addr = IDX_W'(entry_index);
  assign issue   = (state == ST_SCAN) && (iss_cnt < n_used);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= {entry_voltage, entry_code};
    end
    if (issue) begin
      rd_data <= table_mem[iss_cnt[IDX_W-1:0]];
    end
  end

  assign pv = $signed(rd_data[VOLT_W+CODE_W-1:CODE_W]);
  assign pc = rd_data[CODE_W-1:0];

  assign den_w = $signed({hi_v[VOLT_W-1], hi_v}) - $signed({lo_v[VOLT_W-1], lo_v});
  assign dc_w  = $signed({1'b0, hi_c}) - $signed({1'b0, lo_c});
  assign dv_w  = $signed({vin[VOLT_W-1], vin}) - $signed({lo_v[VOLT_W-1], lo_v});

  assign mag_w   = prod[PROD_W-1] ? (~prod + 1'b1) : prod;
  assign trial_w = {rem, quo[QUO_W-1]};
  assign ge_w    = (trial_w >= {1'b0, den});

  // Floor division: a negative quotient with a remainder rounds one further down.
  always_comb begin
    q_mag_w = {2'b00, quo} + {{DIFF_W{1'b0}}, (neg && (rem != '0))};
    q_s_w   = neg ? -$signed(q_mag_w) : $signed(q_mag_w);
    sum_s_w = $signed({2'b00, lo_c}) + q_s_w;
    if (sum_s_w[DIFF_W]) begin
      result_w = '0;
    end else if (sum_s_w[DIFF_W-1]) begin
      result_w = CODE_MAX;
    end else begin
      result_w = sum_s_w[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= COUNT_W'(1);
      done        <= 1'b0;
      rd_vld      <= 1'b0;
      iss_cnt     <= '0;
      match       <= 1'b0;
      found_hi    <= 1'b0;
      div_cnt     <= '0;
    end else begin
      done   <= 1'b0;
      rd_vld <= issue;
      if (cfg_wr_en) begin
        entry_count <= cfg_wr_data;
      end
      if (issue) begin
        rd_idx  <= iss_cnt[IDX_W-1:0];
        iss_cnt <= iss_cnt + 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (start && (mode == MODE_CONVERT)) begin
            vin      <= voltage_in;
            iss_cnt  <= '0;
            match    <= 1'b0;
            found_hi <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // One pass finds the first exact match and, up to the first higher point,
          // the lower and higher bracketing points.
          if (rd_vld) begin
            if (!match && (pv == vin)) begin
              match   <= 1'b1;
              match_c <= pc;
            end
            if (!found_hi) begin
              if ((rd_idx == '0) || ((pv <= vin) && (pv >= lo_v))) begin
                lo_v   <= pv;
                lo_c   <= pc;
                lo_idx <= rd_idx;
              end
              if (pv > vin) begin
                found_hi <= 1'b1;
                hi_idx   <= rd_idx;
                hi_v     <= pv;
                hi_c     <= pc;
              end
            end
          end else if (!issue) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (match) begin
            dac_code <= match_c;
            done     <= 1'b1;
            state    <= ST_IDLE;
          end else if (!found_hi || (hi_idx == lo_idx) || den_w[DIFF_W-1] || (den_w == '0)) begin
            dac_code <= lo_c;
            done     <= 1'b1;
            state    <= ST_IDLE;
          end else begin
            dc    <= dc_w;
            dv    <= dv_w;
            den   <= den_w;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= dc * dv;
          state <= ST_PREP;
        end
        ST_PREP: begin
          // The product magnitude is below 2^16 times the divisor, so the upper bits
          // already form a partial remainder smaller than the divisor.
          neg     <= prod[PROD_W-1];
          rem     <= mag_w[DIFF_W+QUO_W-1:QUO_W];
          quo     <= mag_w[QUO_W-1:0];
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem     <= ge_w ? DIFF_W'(trial_w - {1'b0, den}) : trial_w[DIFF_W-1:0];
          quo     <= {quo[QUO_W-2:0], ge_w};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(QUO_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          dac_code <= result_w;
          done     <= 1'b1;
          state    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
